// File: rtl/qsra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsra_pkg
// Shared types, constants and helpers for the query slot ring allocator.
// ----------------------------------------------------------------------------
package qsra_pkg;

  localparam int MAX_SLOTS    = 1024;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int CNT_W        = 11;
  localparam int ACT_W        = 12;
  localparam int RING_DEPTH   = 4;
  localparam int RING_IW      = $clog2(RING_DEPTH);
  localparam int RESULT_BYTES = 8;
  localparam int RESULT_SHIFT = $clog2(RESULT_BYTES);
  localparam int OFS_W        = 13;
  localparam int REM_W        = 12;
  localparam int REM_STEP_W   = $clog2(REM_W + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [ACT_W-1:0] ACT_MAX = '1;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [2:0] RES_STARTED = 3'd0;
  localparam logic [2:0] RES_GRANTED = 3'd1;
  localparam logic [2:0] RES_RESOLVE = 3'd2;
  localparam logic [2:0] RES_DISCARD = 3'd3;
  localparam logic [2:0] RES_MISUSE  = 3'd4;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_GRANT  = 3'd2;
  localparam logic [2:0] OP_CLOSE  = 3'd3;
  localparam logic [2:0] OP_MISUSE = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic       query_kind;
  } qsra_in_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [SLOT_W-1:0] granted_slot;
    logic [SLOT_W-1:0] resolve_start;
    logic [CNT_W-1:0]  resolve_count;
    logic [OFS_W-1:0]  resolve_offset;
    logic              resolve_kind;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] tail_slot;
    logic              heap_full;
    logic              overflow;
    logic              last;
  } qsra_out_t;

  typedef struct packed {
    logic       capture;
    logic       rem_start;
    logic [2:0] op;
    logic       last;
    logic       reopen;
  } qsra_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       batch_open;
    logic       split;
    logic       out_free;
    logic       rem_busy;
  } qsra_stat_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] sc);
    logic [CNT_W-1:0] c;
    c = sc;
    if (sc < CNT_W'(2)) c = CNT_W'(2);
    if (sc > CNT_W'(MAX_SLOTS)) c = CNT_W'(MAX_SLOTS);
    return c;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  c);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    return (n >= c) ? '0 : n[SLOT_W-1:0];
  endfunction

  function automatic logic [RING_IW-1:0] next_ring(input logic [RING_IW-1:0] i);
    return (i == RING_IW'(RING_DEPTH - 1)) ? '0 : i + RING_IW'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/qsra_rem_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsra_rem_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module qsra_rem_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [qsra_pkg::REM_W-1:0]  dividend,
  input  wire logic [qsra_pkg::CNT_W-1:0]  divisor,
  output logic                             busy,
  output logic [qsra_pkg::SLOT_W-1:0]      remainder
);
  import qsra_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [REM_STEP_W-1:0] step_r, step_nxt;
  logic [REM_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W:0]        shifted;
  logic [CNT_W:0]        diff;

  assign shifted = {rem_r, quo_r[REM_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = REM_STEP_W'(REM_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[REM_W-2:0], 1'b0};
      rem_nxt  = (shifted >= {1'b0, divisor}) ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_nxt = step_r - REM_STEP_W'(1);
      if (step_r == REM_STEP_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r[SLOT_W-1:0];

endmodule
`default_nettype wire

// File: rtl/qsra_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsra_datapath
// Slot pointers, open batch, recent-batch ring, active count and result
// register; executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module qsra_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire qsra_pkg::qsra_in_t         in_data,
  input  wire logic                       cfg_we,
  input  wire logic [qsra_pkg::CNT_W-1:0] cfg_wdata,
  input  wire qsra_pkg::qsra_cmd_t        cmd,
  output qsra_pkg::qsra_stat_t            stat,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output qsra_pkg::qsra_out_t             out_data
);
  import qsra_pkg::*;

  qsra_in_t          req_r;
  logic [CNT_W-1:0]  slot_count_r, slot_count_nxt;
  logic [SLOT_W-1:0] last_alloc_r, last_alloc_nxt;
  logic              open_r, open_nxt;
  logic [SLOT_W-1:0] bstart_r, bstart_nxt;
  logic [CNT_W-1:0]  bcount_r, bcount_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [ACT_W-1:0]  active_r, active_nxt;
  logic [RING_IW-1:0] newest_r, newest_nxt;
  logic [SLOT_W-1:0] rstart_r [RING_DEPTH];
  logic [CNT_W-1:0]  rcount_r [RING_DEPTH];
  logic              ring_we;
  logic              out_valid_r, out_valid_nxt;
  qsra_out_t         out_r, res;

  logic [CNT_W-1:0]   eff;
  logic [CNT_W-1:0]   cfg_eff;
  logic [SLOT_W-1:0]  cur;
  logic [RING_IW-1:0] nw, ni;
  logic [ACT_W:0]     sum;
  logic [ACT_W-1:0]   act1, act2, old_cnt;
  logic               ovf;
  logic               out_free;
  logic               rem_busy;
  logic [SLOT_W-1:0]  rem;
  logic [REM_W-1:0]   dividend;

  assign eff      = eff_count(slot_count_r);
  assign cfg_eff  = eff_count(cfg_wdata);
  assign cur      = next_slot(last_alloc_r, eff);
  assign nw       = next_ring(newest_r);
  assign ni       = next_ring(nw);
  assign sum      = (ACT_W+1)'(active_r) + (ACT_W+1)'(bcount_r);
  assign act1     = sum[ACT_W] ? ACT_MAX : sum[ACT_W-1:0];
  assign ovf      = act1 > ACT_W'(eff);
  assign old_cnt  = ACT_W'(rcount_r[ni]);
  assign act2     = (old_cnt > act1) ? '0 : act1 - old_cnt;
  assign dividend = REM_W'(bstart_r) + REM_W'(bcount_r) - REM_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  qsra_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.rem_start),
    .dividend  (dividend),
    .divisor   (eff),
    .busy      (rem_busy),
    .remainder (rem)
  );

  always_comb begin
    slot_count_nxt = slot_count_r;
    last_alloc_nxt = last_alloc_r;
    open_nxt       = open_r;
    bstart_nxt     = bstart_r;
    bcount_nxt     = bcount_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    active_nxt     = active_r;
    newest_nxt     = newest_r;
    ring_we        = 1'b0;
    res            = '0;
    case (cmd.op)
      OP_START: begin
        bstart_nxt      = cur;
        bcount_nxt      = '0;
        open_nxt        = 1'b1;
        res.result_kind = RES_STARTED;
      end
      OP_GRANT: begin
        if (bcount_r != CNT_MAX) bcount_nxt = bcount_r + CNT_W'(1);
        last_alloc_nxt   = cur;
        res.result_kind  = RES_GRANTED;
        res.granted_slot = cur;
      end
      OP_CLOSE: begin
        open_nxt = 1'b0;
        if (bcount_r == '0) begin
          res.result_kind = RES_DISCARD;
        end else begin
          tail_nxt           = rem;
          active_nxt         = act2;
          newest_nxt         = nw;
          ring_we            = 1'b1;
          head_nxt           = rstart_r[ni];
          res.result_kind    = RES_RESOLVE;
          res.resolve_start  = bstart_r;
          res.resolve_count  = bcount_r;
          res.resolve_offset = OFS_W'(bstart_r) << RESULT_SHIFT;
          res.resolve_kind   = req_r.query_kind;
          res.overflow       = ovf;
        end
        if (cmd.reopen) begin
          bstart_nxt = cur;
          bcount_nxt = '0;
          open_nxt   = 1'b1;
        end
      end
      OP_MISUSE: begin
        res.result_kind = RES_MISUSE;
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      slot_count_nxt = cfg_wdata;
      last_alloc_nxt = SLOT_W'(cfg_eff - CNT_W'(1));
    end
    res.head_slot = head_nxt;
    res.tail_slot = tail_nxt;
    res.heap_full = (next_slot(tail_nxt, eff) == head_nxt);
    res.last      = cmd.last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op != OP_NONE) out_valid_nxt = 1'b1;
    else if (!out_stall)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_W'(MAX_SLOTS);
      last_alloc_r <= SLOT_W'(MAX_SLOTS - 1);
      open_r       <= 1'b0;
      bstart_r     <= '0;
      bcount_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      active_r     <= '0;
      newest_r     <= RING_IW'(RING_DEPTH - 1);
      out_valid_r  <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        rstart_r[i] <= '0;
        rcount_r[i] <= '0;
      end
    end else begin
      slot_count_r <= slot_count_nxt;
      last_alloc_r <= last_alloc_nxt;
      open_r       <= open_nxt;
      bstart_r     <= bstart_nxt;
      bcount_r     <= bcount_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      active_r     <= active_nxt;
      newest_r     <= newest_nxt;
      out_valid_r  <= out_valid_nxt;
      if (ring_we) begin
        rstart_r[nw] <= bstart_r;
        rcount_r[nw] <= bcount_r;
      end
    end
    if (cmd.capture) req_r <= in_data;
    if (cmd.op != OP_NONE) out_r <= res;
  end

  assign stat.req_type   = req_r.req_type;
  assign stat.batch_open = open_r;
  assign stat.split      = bstart_r > cur;
  assign stat.out_free   = out_free;
  assign stat.rem_busy   = rem_busy;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: rtl/qsra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsra_ctrl
// Request sequencer: captures a request, picks the operations it needs and
// issues them to the datapath as the result register frees up.
// ----------------------------------------------------------------------------
module qsra_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire qsra_pkg::qsra_stat_t stat,
  output qsra_pkg::qsra_cmd_t       cmd
);
  import qsra_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_REMW   = 2'd2;
  localparam logic [1:0] ST_GRANT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       close_path;

  assign close_path = stat.batch_open &&
                      (stat.req_type == REQ_END ||
                       (stat.req_type == REQ_ALLOC && stat.split));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (close_path) begin
          cmd.rem_start = 1'b1;
          state_nxt     = ST_REMW;
        end else if (stat.out_free) begin
          if (stat.req_type == REQ_START && !stat.batch_open) cmd.op = OP_START;
          else if (stat.req_type == REQ_ALLOC && stat.batch_open) cmd.op = OP_GRANT;
          else cmd.op = OP_MISUSE;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REMW: begin
        if (!stat.rem_busy && stat.out_free) begin
          cmd.op = OP_CLOSE;
          if (stat.req_type == REQ_ALLOC) begin
            cmd.reopen = 1'b1;
            state_nxt  = ST_GRANT;
          end else begin
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_GRANT: begin
        if (stat.out_free) begin
          cmd.op    = OP_GRANT;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// File: rtl/query_slot_ring_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// query_slot_ring_allocator
// Batched query slot allocator over a circular heap with resolve commands.
// ----------------------------------------------------------------------------
// One request is taken at a time. A start, allocate or misused request
// is captured, decided and issued as one operation; an end request also
// waits in a remainder state, and an allocate that wraps inside an open
// batch is followed by a grant state, because closing a batch runs a
// 12-step remainder unit to fold the tail slot into the current slot
// count. A stalled result register adds its stall time. A request may be
// accepted while the previous result is still waiting on the output.
// ----------------------------------------------------------------------------
module query_slot_ring_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire qsra_pkg::qsra_in_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output qsra_pkg::qsra_out_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [qsra_pkg::CNT_W-1:0] cfg_wdata
);
  import qsra_pkg::*;

  qsra_cmd_t  cmd;
  qsra_stat_t stat;

  qsra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  qsra_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: dv/qsra_ring_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsra_ring_check
// Watches the request, result and register ports of the slot ring allocator.
// It keeps its own copy of the batch, pointer and ring state. It works out
// the results that each accepted request should produce and compares every
// accepted result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module qsra_ring_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  qsra_pkg::qsra_in_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  qsra_pkg::qsra_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [qsra_pkg::CNT_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         due_count
);
  import qsra_pkg::*;

  logic [CNT_W-1:0]  slot_count;
  logic [SLOT_W-1:0] last_alloc;
  logic              batch_open;
  logic [SLOT_W-1:0] batch_start;
  logic [CNT_W-1:0]  batch_count;
  logic [SLOT_W-1:0] head_ptr;
  logic [SLOT_W-1:0] tail_ptr;
  logic [ACT_W-1:0]  active;
  logic [SLOT_W-1:0] ring_start [RING_DEPTH];
  logic [CNT_W-1:0]  ring_count [RING_DEPTH];
  int                newest;

  qsra_out_t responses[$];
  qsra_out_t want;
  int        mismatches = 0;

  function automatic int eff_slots();
    int c;
    c = slot_count;
    if (c < 2) c = 2;
    if (c > MAX_SLOTS) c = MAX_SLOTS;
    return c;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    int n;
    n = int'(s) + 1;
    return (n >= eff_slots()) ? '0 : SLOT_W'(n);
  endfunction

  task automatic post(input logic [2:0] kind, input logic [SLOT_W-1:0] grant,
                      input logic [SLOT_W-1:0] rs, input logic [CNT_W-1:0] rc,
                      input logic rk, input logic ovf, input logic fin);
    qsra_out_t r;
    r.result_kind    = kind;
    r.granted_slot   = grant;
    r.resolve_start  = rs;
    r.resolve_count  = rc;
    r.resolve_offset = OFS_W'(int'(rs) * RESULT_BYTES);
    r.resolve_kind   = rk;
    r.head_slot      = head_ptr;
    r.tail_slot      = tail_ptr;
    r.heap_full      = (slot_after(tail_ptr) == head_ptr);
    r.overflow       = ovf;
    r.last           = fin;
    responses.push_back(r);
  endtask

  task automatic close_batch(input logic qk, input logic fin);
    int   c;
    int   sum;
    int   ni;
    logic ovf;
    c = eff_slots();
    batch_open = 1'b0;
    if (batch_count == '0) begin
      post(RES_DISCARD, '0, '0, '0, 1'b0, 1'b0, fin);
      return;
    end
    tail_ptr = SLOT_W'((int'(batch_start) + int'(batch_count) - 1) % c);
    sum = int'(active) + int'(batch_count);
    active = (sum > int'(ACT_MAX)) ? ACT_MAX : ACT_W'(sum);
    ovf = (int'(active) > c);
    newest = (newest + 1) % RING_DEPTH;
    ring_start[newest] = batch_start;
    ring_count[newest] = batch_count;
    ni = (newest + 1) % RING_DEPTH;
    head_ptr = ring_start[ni];
    if (int'(ring_count[ni]) > int'(active)) active = '0;
    else active = active - ACT_W'(ring_count[ni]);
    post(RES_RESOLVE, '0, batch_start, batch_count, qk, ovf, fin);
  endtask

  task automatic step_allocator(input logic [1:0] rt, input logic qk);
    logic [SLOT_W-1:0] cur;
    if (rt == REQ_START && !batch_open) begin
      batch_start = slot_after(last_alloc);
      batch_count = '0;
      batch_open  = 1'b1;
      post(RES_STARTED, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    end else if (rt == REQ_ALLOC && batch_open) begin
      cur = slot_after(last_alloc);
      if (batch_start > cur) begin
        close_batch(qk, 1'b0);
        batch_start = cur;
        batch_count = '0;
        batch_open  = 1'b1;
      end
      if (batch_count != CNT_MAX) batch_count = batch_count + 1'b1;
      last_alloc = cur;
      post(RES_GRANTED, cur, '0, '0, 1'b0, 1'b0, 1'b1);
    end else if (rt == REQ_END && batch_open) begin
      close_batch(qk, 1'b1);
    end else begin
      post(RES_MISUSE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic cmp(input string fname, input int unsigned exp_v, input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, fname, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_count  = CNT_W'(MAX_SLOTS);
      last_alloc  = SLOT_W'(MAX_SLOTS - 1);
      batch_open  = 1'b0;
      batch_start = '0;
      batch_count = '0;
      head_ptr    = '0;
      tail_ptr    = '0;
      active      = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_start[i] = '0;
        ring_count[i] = '0;
      end
      newest = RING_DEPTH - 1;
      responses.delete();
    end else begin
      if (cfg_we) begin
        slot_count = cfg_wdata;
        last_alloc = SLOT_W'(eff_slots() - 1);
      end
      if (out_valid && !out_stall) begin
        if (responses.size() == 0) begin
          $display("%0t: result kind %0d arrived with no request owed (expected none)",
                   $time, out_data.result_kind);
          mismatches++;
        end else begin
          want = responses.pop_front();
          cmp("result_kind", want.result_kind, out_data.result_kind);
          cmp("granted_slot", want.granted_slot, out_data.granted_slot);
          cmp("resolve_start", want.resolve_start, out_data.resolve_start);
          cmp("resolve_count", want.resolve_count, out_data.resolve_count);
          cmp("resolve_offset", want.resolve_offset, out_data.resolve_offset);
          cmp("resolve_kind", want.resolve_kind, out_data.resolve_kind);
          cmp("head_slot", want.head_slot, out_data.head_slot);
          cmp("tail_slot", want.tail_slot, out_data.tail_slot);
          cmp("heap_full", want.heap_full, out_data.heap_full);
          cmp("overflow", want.overflow, out_data.overflow);
          cmp("last", want.last, out_data.last);
        end
      end
      if (in_valid && !in_stall) step_allocator(in_data.req_type, in_data.query_kind);
    end
    due_count  <= responses.size();
    fail_count <= mismatches;
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Request generator and verdict for the query slot ring allocator. A short
// directed run covers misuse, empty batches, wrap splits and a register
// write under an open batch. Random batch sequences follow across many slot
// counts, with random gaps on both sides and one long result hold-off. A
// final run of long batches over two slots pushes the active count past
// the slot count.
// ----------------------------------------------------------------------------
module tb_top;
  import qsra_pkg::*;

  typedef enum int {PACE_NONE, PACE_LIGHT, PACE_FULL} pace_t;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         RANDOM_TARGET = 950;
  localparam int         LONG_BATCH    = 150;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 24;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  qsra_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  qsra_out_t        out_data;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int               fail_count;
  int               due_count;
  pace_t            pace;
  logic             hold_off;
  int               cur_slots;
  int               sent;

  query_slot_ring_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  qsra_ring_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int draw_wait();
    if (pace == PACE_NONE) return 0;
    if (pace == PACE_LIGHT) return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send(input logic [1:0] rt, input logic qk);
    qsra_in_t pkt;
    int       gap;
    pkt.req_type   = rt;
    pkt.query_kind = qk;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= pkt;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_slot_count(input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_slots = (v < 2) ? 2 : (v > MAX_SLOTS) ? MAX_SLOTS : int'(v);
  endtask

  task automatic run_phase(input int n_items);
    int done;
    int k;
    int j;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        done++;
      end else begin
        k = $urandom_range(0, (cur_slots > 20) ? 40 : 2 * cur_slots + 2);
        send(REQ_START, 1'($urandom_range(0, 1)));
        for (j = 0; j < k; j++) send(REQ_ALLOC, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) != 0) send(REQ_END, 1'($urandom_range(0, 1)));
        done += k + 2;
      end
    end
  endtask

  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int               p;
    int               b;
    int               j;
    logic [CNT_W-1:0] val;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    hold_off  = 1'b0;
    pace      = PACE_FULL;
    cur_slots = MAX_SLOTS;
    sent      = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send(REQ_ALLOC, 1'b0);
    send(REQ_END, 1'b1);
    send(REQ_UNUSED, 1'b1);
    send(REQ_START, 1'b0);
    send(REQ_START, 1'b1);
    send(REQ_END, 1'b0);
    send(REQ_START, 1'b1);
    repeat (3) send(REQ_ALLOC, 1'b0);
    send(REQ_END, 1'b1);
    send(REQ_START, 1'b0);
    send(REQ_ALLOC, 1'b1);
    send(REQ_END, 1'b0);
    settle();
    set_slot_count(11'd3);
    send(REQ_START, 1'b0);
    send(REQ_ALLOC, 1'b0);
    send(REQ_END, 1'b1);
    send(REQ_START, 1'b1);
    repeat (3) send(REQ_ALLOC, 1'b1);
    send(REQ_END, 1'b0);
    send(REQ_START, 1'b0);
    settle();
    set_slot_count(11'd0);
    send(REQ_ALLOC, 1'b1);
    send(REQ_END, 1'b1);

    // random batches over a spread of slot counts, open batches carried over
    p = 0;
    while (sent < RANDOM_TARGET) begin
      settle();
      case (p % 8)
        0: val = 11'd2;
        1: val = 11'd2047;
        2: val = CNT_W'($urandom_range(3, 12));
        3: val = 11'd0;
        4: val = 11'd1024;
        5: val = 11'd1;
        6: val = CNT_W'($urandom_range(0, 2047));
        default: val = CNT_W'($urandom_range(2, 24));
      endcase
      set_slot_count(val);
      pace = pace_t'($urandom_range(0, 2));
      if (p == 2) begin
        pace = PACE_NONE;
        hold_off = 1'b1;
      end
      run_phase($urandom_range(40, 120));
      p++;
    end

    // push the active count past the slot count with long batches
    settle();
    set_slot_count(11'd2);
    pace = PACE_NONE;
    for (b = 0; b < 3; b++) begin
      send(REQ_START, 1'($urandom_range(0, 1)));
      for (j = 0; j < LONG_BATCH; j++) send(REQ_ALLOC, 1'($urandom_range(0, 1)));
      send(REQ_END, 1'($urandom_range(0, 1)));
    end
    pace = PACE_LIGHT;
    run_phase(30);

    settle();
    if (fail_count == 0 && due_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
